FILE: src/ray_triangle_nearest_hit_defines.svh
// ----------------------------------------------------------------------------
// Ray/triangle nearest hit: assertion macros
// Shared concurrent assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_NEAREST_HIT_DEFINES_SVH
`define RAY_TRIANGLE_NEAREST_HIT_DEFINES_SVH

// same-cycle implication
`define RTNH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RTNH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/rtnh_pkg.sv
// ----------------------------------------------------------------------------
// rtnh_pkg
// Types, widths and the product program of the ray/triangle hit engine.
// ----------------------------------------------------------------------------
package rtnh_pkg;

   localparam int MAX_TRIANGLES = 4096;
   localparam int FRAC_BITS     = 16;
   localparam int COORD_W       = 32;
   localparam int DIR_W         = 18;
   localparam int DIST_W        = 31;
   localparam int INDEX_W       = 12;
   localparam int CNT_W         = $clog2(MAX_TRIANGLES);

   localparam int DIFF_W    = COORD_W + 1;
   localparam int P_W       = DIR_W + DIFF_W + 1;
   localparam int Q_W       = 2 * DIFF_W + 1;
   localparam int DOT_W     = P_W + DIFF_W + 3;
   localparam int TN_W      = Q_W + DIFF_W + 2;
   localparam int ACC_W     = TN_W + 1;
   localparam int XS_W      = Q_W + DIFF_W;
   localparam int DIV_SHIFT = DIST_W - 1;
   localparam int SAT_SHIFT = DIST_W - FRAC_BITS;
   localparam int NUM_W     = (TN_W + FRAC_BITS > DOT_W + DIV_SHIFT) ?
                              TN_W + FRAC_BITS : DOT_W + DIV_SHIFT;
   localparam int DCNT_W    = $clog2(DIST_W);

   localparam logic [DIST_W-1:0] SAT_DIST = {DIST_W{1'b1}};

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [DIR_W-1:0] DIR_Z_RESET = DIR_W'(1 << FRAC_BITS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int TERM_W = 5;
   localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(23);

   typedef enum logic [2:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_ORIGIN_Z = 3'd2,
      REG_DIR_X    = 3'd3,
      REG_DIR_Y    = 3'd4,
      REG_DIR_Z    = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_MUL, ST_NORM, ST_CHECK, ST_DIV, ST_UPDATE, ST_EMIT
   } back_state_type;

   typedef enum logic [3:0] {
      X_E2X, X_E2Y, X_E2Z, X_TVX, X_TVY, X_TVZ, X_PX, X_PY, X_PZ, X_QX, X_QY, X_QZ
   } xsel_type;

   typedef enum logic [3:0] {
      Y_DX, Y_DY, Y_DZ, Y_E1X, Y_E1Y, Y_E1Z, Y_TVX, Y_TVY, Y_TVZ, Y_E2X, Y_E2Y, Y_E2Z
   } ysel_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_P0, DST_P1, DST_P2, DST_Q0, DST_Q1, DST_Q2,
      DST_D, DST_UN, DST_VN, DST_TN
   } dst_type;

   typedef struct packed {
      xsel_type xsel;
      ysel_type ysel;
      logic     neg;
      dst_type  dst;
   } term_type;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] e1;
      logic [2:0][DIFF_W-1:0] e2;
      logic [2:0][DIFF_W-1:0] tv;
      logic                   last;
   } trig_type;

   typedef struct packed {
      logic     valid;
      trig_type data;
   } queue_out_type;

   // P = dir x E2, Q = T x E1, then d = P.E1, un = P.T, vn = Q.dir, tn = Q.E2
   function automatic term_type term_of(input logic [TERM_W-1:0] idx);
      term_type t;
      unique case (idx)
         5'd0:    t = '{X_E2Z, Y_DY,  1'b0, DST_NONE};
         5'd1:    t = '{X_E2Y, Y_DZ,  1'b1, DST_P0};
         5'd2:    t = '{X_E2X, Y_DZ,  1'b0, DST_NONE};
         5'd3:    t = '{X_E2Z, Y_DX,  1'b1, DST_P1};
         5'd4:    t = '{X_E2Y, Y_DX,  1'b0, DST_NONE};
         5'd5:    t = '{X_E2X, Y_DY,  1'b1, DST_P2};
         5'd6:    t = '{X_TVY, Y_E1Z, 1'b0, DST_NONE};
         5'd7:    t = '{X_TVZ, Y_E1Y, 1'b1, DST_Q0};
         5'd8:    t = '{X_TVZ, Y_E1X, 1'b0, DST_NONE};
         5'd9:    t = '{X_TVX, Y_E1Z, 1'b1, DST_Q1};
         5'd10:   t = '{X_TVX, Y_E1Y, 1'b0, DST_NONE};
         5'd11:   t = '{X_TVY, Y_E1X, 1'b1, DST_Q2};
         5'd12:   t = '{X_PX,  Y_E1X, 1'b0, DST_NONE};
         5'd13:   t = '{X_PY,  Y_E1Y, 1'b0, DST_NONE};
         5'd14:   t = '{X_PZ,  Y_E1Z, 1'b0, DST_D};
         5'd15:   t = '{X_PX,  Y_TVX, 1'b0, DST_NONE};
         5'd16:   t = '{X_PY,  Y_TVY, 1'b0, DST_NONE};
         5'd17:   t = '{X_PZ,  Y_TVZ, 1'b0, DST_UN};
         5'd18:   t = '{X_QX,  Y_DX,  1'b0, DST_NONE};
         5'd19:   t = '{X_QY,  Y_DY,  1'b0, DST_NONE};
         5'd20:   t = '{X_QZ,  Y_DZ,  1'b0, DST_VN};
         5'd21:   t = '{X_QX,  Y_E2X, 1'b0, DST_NONE};
         5'd22:   t = '{X_QY,  Y_E2Y, 1'b0, DST_NONE};
         5'd23:   t = '{X_QZ,  Y_E2Z, 1'b0, DST_TN};
         default: t = '{X_E2X, Y_DX,  1'b0, DST_NONE};
      endcase
      return t;
   endfunction

endpackage

FILE: src/rtnh_req_if.sv
// ----------------------------------------------------------------------------
// rtnh_req_if
// Triangle channel: valid/ready with three vertices and a last flag.
// ----------------------------------------------------------------------------
interface rtnh_req_if;
   import rtnh_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] vertex_a_x;
   logic [COORD_W-1:0] vertex_a_y;
   logic [COORD_W-1:0] vertex_a_z;
   logic [COORD_W-1:0] vertex_b_x;
   logic [COORD_W-1:0] vertex_b_y;
   logic [COORD_W-1:0] vertex_b_z;
   logic [COORD_W-1:0] vertex_c_x;
   logic [COORD_W-1:0] vertex_c_y;
   logic [COORD_W-1:0] vertex_c_z;
   logic               last_triangle;

   modport source (
      output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
             vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, last_triangle,
      input  ready
   );

   modport sink (
      input  valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
             vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, last_triangle,
      output ready
   );
endinterface

FILE: src/rtnh_rsp_if.sv
// ----------------------------------------------------------------------------
// rtnh_rsp_if
// Result channel: valid/ready with hit flag, distance and triangle index.
// ----------------------------------------------------------------------------
interface rtnh_rsp_if;
   import rtnh_pkg::*;

   logic               valid;
   logic               ready;
   logic               hit_found;
   logic [DIST_W-1:0]  hit_distance;
   logic [INDEX_W-1:0] hit_index;

   modport source (output valid, hit_found, hit_distance, hit_index, input ready);
   modport sink   (input valid, hit_found, hit_distance, hit_index, output ready);
endinterface

FILE: src/rtnh_front.sv
// ----------------------------------------------------------------------------
// rtnh_front
// Accepts triangles, forms E1, E2 and T, and buffers them in a short queue.
// ----------------------------------------------------------------------------
module rtnh_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rtnh_pkg::COORD_W-1:0]  origin_x,
   input  logic [rtnh_pkg::COORD_W-1:0]  origin_y,
   input  logic [rtnh_pkg::COORD_W-1:0]  origin_z,
   rtnh_req_if.sink                      req,
   input  logic                          tri_pop,
   output rtnh_pkg::queue_out_type       q_out
);
   import rtnh_pkg::*;

   trig_type          queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   trig_type          entry;
   logic              push;
   logic              pop;
   logic [COORD_W-1:0] a_v [3];
   logic [COORD_W-1:0] b_v [3];
   logic [COORD_W-1:0] c_v [3];
   logic [COORD_W-1:0] o_v [3];

   assign a_v = '{req.vertex_a_x, req.vertex_a_y, req.vertex_a_z};
   assign b_v = '{req.vertex_b_x, req.vertex_b_y, req.vertex_b_z};
   assign c_v = '{req.vertex_c_x, req.vertex_c_y, req.vertex_c_z};
   assign o_v = '{origin_x, origin_y, origin_z};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         entry.e1[i] = {b_v[i][COORD_W-1], b_v[i]} - {a_v[i][COORD_W-1], a_v[i]};
         entry.e2[i] = {c_v[i][COORD_W-1], c_v[i]} - {a_v[i][COORD_W-1], a_v[i]};
         entry.tv[i] = {o_v[i][COORD_W-1], o_v[i]} - {a_v[i][COORD_W-1], a_v[i]};
      end
      entry.last = req.last_triangle;
   end

   assign req.ready   = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push        = req.valid && req.ready;
   assign pop         = tri_pop && (count_ff != '0);
   assign q_out.valid = (count_ff != '0);
   assign q_out.data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

FILE: src/rtnh_back.sv
// ----------------------------------------------------------------------------
// rtnh_back
// Serial multiply-accumulate sequencer, hit test, restoring divider,
// nearest-hit tracking and the result register.
// ----------------------------------------------------------------------------
module rtnh_back (
   input  logic                         clock,
   input  logic                         reset,
   input  rtnh_pkg::queue_out_type      q_out,
   output logic                         tri_pop,
   input  logic [rtnh_pkg::DIR_W-1:0]   dir_x,
   input  logic [rtnh_pkg::DIR_W-1:0]   dir_y,
   input  logic [rtnh_pkg::DIR_W-1:0]   dir_z,
   rtnh_rsp_if.source                   rsp
);
   import rtnh_pkg::*;

   back_state_type      state_ff, state_in;
   trig_type            trig_ff, trig_in;
   logic [TERM_W-1:0]   term_ff, term_in;
   logic [XS_W-1:0]     xs_ff, xs_in;
   logic [DIFF_W-1:0]   ym_ff, ym_in;
   logic                neg_ff, neg_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [P_W-1:0]      p_ff [3];
   logic [P_W-1:0]      p_in [3];
   logic [Q_W-1:0]      q_ff [3];
   logic [Q_W-1:0]      q_in [3];
   logic [DOT_W-1:0]    d_ff, d_in, un_ff, un_in, vn_ff, vn_in;
   logic [TN_W-1:0]     tn_ff, tn_in;
   logic                hit_ff, hit_in;
   logic [NUM_W-1:0]    num_ff, num_in, den_ff, den_in;
   logic [DIST_W-1:0]   quo_ff, quo_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic                best_valid_ff, best_valid_in;
   logic [DIST_W-1:0]   best_dist_ff, best_dist_in;
   logic [INDEX_W-1:0]  best_idx_ff, best_idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;
   logic [INDEX_W-1:0]  rsp_idx_ff, rsp_idx_in;

   term_type            cur;
   logic [Q_W-1:0]      x_val, x_mag;
   logic [DIFF_W-1:0]   y_val, y_mag;
   logic [ACC_W-1:0]    xs_ext, addend, acc_sum;
   logic                mul_done;
   logic [DOT_W:0]      uv_sum;
   logic                hit_now, sat_now, ge;
   logic                out_free, emit_fire;

   assign cur      = term_of(term_ff);
   assign mul_done = (ym_ff[DIFF_W-1:1] == '0);
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      unique case (cur.xsel)
         X_E2X:   x_val = {{(Q_W-DIFF_W){trig_ff.e2[0][DIFF_W-1]}}, trig_ff.e2[0]};
         X_E2Y:   x_val = {{(Q_W-DIFF_W){trig_ff.e2[1][DIFF_W-1]}}, trig_ff.e2[1]};
         X_E2Z:   x_val = {{(Q_W-DIFF_W){trig_ff.e2[2][DIFF_W-1]}}, trig_ff.e2[2]};
         X_TVX:   x_val = {{(Q_W-DIFF_W){trig_ff.tv[0][DIFF_W-1]}}, trig_ff.tv[0]};
         X_TVY:   x_val = {{(Q_W-DIFF_W){trig_ff.tv[1][DIFF_W-1]}}, trig_ff.tv[1]};
         X_TVZ:   x_val = {{(Q_W-DIFF_W){trig_ff.tv[2][DIFF_W-1]}}, trig_ff.tv[2]};
         X_PX:    x_val = {{(Q_W-P_W){p_ff[0][P_W-1]}}, p_ff[0]};
         X_PY:    x_val = {{(Q_W-P_W){p_ff[1][P_W-1]}}, p_ff[1]};
         X_PZ:    x_val = {{(Q_W-P_W){p_ff[2][P_W-1]}}, p_ff[2]};
         X_QX:    x_val = q_ff[0];
         X_QY:    x_val = q_ff[1];
         X_QZ:    x_val = q_ff[2];
         default: x_val = '0;
      endcase
      unique case (cur.ysel)
         Y_DX:    y_val = {{(DIFF_W-DIR_W){dir_x[DIR_W-1]}}, dir_x};
         Y_DY:    y_val = {{(DIFF_W-DIR_W){dir_y[DIR_W-1]}}, dir_y};
         Y_DZ:    y_val = {{(DIFF_W-DIR_W){dir_z[DIR_W-1]}}, dir_z};
         Y_E1X:   y_val = trig_ff.e1[0];
         Y_E1Y:   y_val = trig_ff.e1[1];
         Y_E1Z:   y_val = trig_ff.e1[2];
         Y_TVX:   y_val = trig_ff.tv[0];
         Y_TVY:   y_val = trig_ff.tv[1];
         Y_TVZ:   y_val = trig_ff.tv[2];
         Y_E2X:   y_val = trig_ff.e2[0];
         Y_E2Y:   y_val = trig_ff.e2[1];
         Y_E2Z:   y_val = trig_ff.e2[2];
         default: y_val = '0;
      endcase
      x_mag   = x_val[Q_W-1] ? (~x_val + 1'b1) : x_val;
      y_mag   = y_val[DIFF_W-1] ? (~y_val + 1'b1) : y_val;
      xs_ext  = ACC_W'(xs_ff);
      addend  = neg_ff ? (~xs_ext + 1'b1) : xs_ext;
      acc_sum = acc_ff + (ym_ff[0] ? addend : '0);
      uv_sum  = {1'b0, un_ff} + {1'b0, vn_ff};
      hit_now = (d_ff != '0) && !un_ff[DOT_W-1] && !vn_ff[DOT_W-1] && !tn_ff[TN_W-1]
                && (uv_sum <= {1'b0, d_ff});
      sat_now = (ACC_W'(tn_ff) >= ACC_W'({d_ff, {SAT_SHIFT{1'b0}}}));
      ge      = (num_ff >= den_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (q_out.valid) state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_MUL;
         ST_MUL:    if (mul_done) state_in = (term_ff == LAST_TERM) ? ST_NORM : ST_LOAD;
         ST_NORM:   state_in = ST_CHECK;
         ST_CHECK:  state_in = (!hit_now || sat_now) ? ST_UPDATE : ST_DIV;
         ST_DIV:    if (dcnt_ff == '0) state_in = ST_UPDATE;
         ST_UPDATE: state_in = trig_ff.last ? ST_EMIT : ST_IDLE;
         ST_EMIT:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      tri_pop   = 1'b0;
      emit_fire = 1'b0;
      unique case (state_ff)
         ST_IDLE: tri_pop   = q_out.valid;
         ST_EMIT: emit_fire = out_free;
         default: ;
      endcase
   end

   always_comb begin
      trig_in       = trig_ff;
      term_in       = term_ff;
      xs_in         = xs_ff;
      ym_in         = ym_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      d_in          = d_ff;
      un_in         = un_ff;
      vn_in         = vn_ff;
      tn_in         = tn_ff;
      hit_in        = hit_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      quo_in        = quo_ff;
      dcnt_in       = dcnt_ff;
      best_valid_in = best_valid_ff;
      best_dist_in  = best_dist_ff;
      best_idx_in   = best_idx_ff;
      count_in      = count_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_valid_in  = rsp.ready ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         ST_IDLE: begin
            trig_in = q_out.data;
            term_in = '0;
            acc_in  = '0;
         end
         ST_LOAD: begin
            xs_in  = XS_W'(x_mag);
            ym_in  = y_mag;
            neg_in = cur.neg ^ x_val[Q_W-1] ^ y_val[DIFF_W-1];
         end
         ST_MUL: begin
            xs_in  = xs_ff << 1;
            ym_in  = ym_ff >> 1;
            acc_in = acc_sum;
            if (mul_done) begin
               term_in = term_ff + 1'b1;
               if (cur.dst != DST_NONE) begin
                  acc_in = '0;
               end
               case (cur.dst)
                  DST_P0:  p_in[0] = acc_sum[P_W-1:0];
                  DST_P1:  p_in[1] = acc_sum[P_W-1:0];
                  DST_P2:  p_in[2] = acc_sum[P_W-1:0];
                  DST_Q0:  q_in[0] = acc_sum[Q_W-1:0];
                  DST_Q1:  q_in[1] = acc_sum[Q_W-1:0];
                  DST_Q2:  q_in[2] = acc_sum[Q_W-1:0];
                  DST_D:   d_in    = acc_sum[DOT_W-1:0];
                  DST_UN:  un_in   = acc_sum[DOT_W-1:0];
                  DST_VN:  vn_in   = acc_sum[DOT_W-1:0];
                  DST_TN:  tn_in   = acc_sum[TN_W-1:0];
                  default: ;
               endcase
            end
         end
         ST_NORM: begin
            if (d_ff[DOT_W-1]) begin
               d_in  = ~d_ff + 1'b1;
               un_in = ~un_ff + 1'b1;
               vn_in = ~vn_ff + 1'b1;
               tn_in = ~tn_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            hit_in  = hit_now;
            num_in  = NUM_W'({tn_ff, {FRAC_BITS{1'b0}}});
            den_in  = NUM_W'({d_ff, {DIV_SHIFT{1'b0}}});
            quo_in  = sat_now ? SAT_DIST : '0;
            dcnt_in = DCNT_W'(DIST_W - 1);
         end
         ST_DIV: begin
            num_in  = ge ? (num_ff - den_ff) : num_ff;
            den_in  = den_ff >> 1;
            quo_in  = {quo_ff[DIST_W-2:0], ge};
            dcnt_in = dcnt_ff - 1'b1;
         end
         ST_UPDATE: begin
            if (hit_ff && (!best_valid_ff || (quo_ff < best_dist_ff))) begin
               best_valid_in = 1'b1;
               best_dist_in  = quo_ff;
               best_idx_in   = INDEX_W'(count_ff);
            end
            count_in = (count_ff == CNT_W'(MAX_TRIANGLES - 1)) ? '0 : count_ff + 1'b1;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = best_valid_ff;
               rsp_dist_in   = best_valid_ff ? best_dist_ff : '0;
               rsp_idx_in    = best_valid_ff ? best_idx_ff : '0;
               best_valid_in = 1'b0;
               best_dist_in  = '0;
               best_idx_in   = '0;
               count_in      = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         best_valid_ff <= 1'b0;
         best_dist_ff  <= '0;
         best_idx_ff   <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         best_valid_ff <= best_valid_in;
         best_dist_ff  <= best_dist_in;
         best_idx_ff   <= best_idx_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      trig_ff     <= trig_in;
      term_ff     <= term_in;
      xs_ff       <= xs_in;
      ym_ff       <= ym_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      d_ff        <= d_in;
      un_ff       <= un_in;
      vn_ff       <= vn_in;
      tn_ff       <= tn_in;
      hit_ff      <= hit_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      dcnt_ff     <= dcnt_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.hit_found    = rsp_hit_ff;
   assign rsp.hit_distance = rsp_dist_ff;
   assign rsp.hit_index    = rsp_idx_ff;

endmodule

FILE: src/ray_triangle_nearest_hit.sv
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit
// Nearest ray/triangle hit over a streamed mesh, exact fixed point.
// ----------------------------------------------------------------------------
// channel   | role                  | handshake
// req_chan  | triangle in           | valid/ready, one triangle per transaction
// rsp_chan  | nearest hit out       | valid/ready, one transaction per last triangle
// csr_*     | ray origin, direction | APB-style writes and reads, pready tied high
//
// A triangle is loaded, then its 24 products run through the shared bit-serial
// multiplier, each ending early on the bit length of the narrow operand; then
// come the sign normalisation and the hit test, the divider only when it hits
// without saturating, and the result step on a last triangle.
// A two-entry queue lets the front take triangles while the back is busy.
// Reset has no clearing pass; a stalled result holds the back.
// ----------------------------------------------------------------------------
`include "ray_triangle_nearest_hit_defines.svh"

module ray_triangle_nearest_hit (
   input  logic                              clock,
   input  logic                              reset,
   rtnh_req_if.sink                          req_chan,
   rtnh_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rtnh_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rtnh_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rtnh_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import rtnh_pkg::*;

   logic [COORD_W-1:0] origin_x_ff, origin_x_in;
   logic [COORD_W-1:0] origin_y_ff, origin_y_in;
   logic [COORD_W-1:0] origin_z_ff, origin_z_in;
   logic [DIR_W-1:0]   dir_x_ff, dir_x_in;
   logic [DIR_W-1:0]   dir_y_ff, dir_y_in;
   logic [DIR_W-1:0]   dir_z_ff, dir_z_in;
   logic               csr_wr;
   reg_index_type      reg_idx;
   queue_out_type      q_out;
   logic               tri_pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      origin_z_in = origin_z_ff;
      dir_x_in    = dir_x_ff;
      dir_y_in    = dir_y_ff;
      dir_z_in    = dir_z_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            REG_ORIGIN_X: origin_x_in = csr_pwdata;
            REG_ORIGIN_Y: origin_y_in = csr_pwdata;
            REG_ORIGIN_Z: origin_z_in = csr_pwdata;
            REG_DIR_X:    dir_x_in    = csr_pwdata[DIR_W-1:0];
            REG_DIR_Y:    dir_y_in    = csr_pwdata[DIR_W-1:0];
            REG_DIR_Z:    dir_z_in    = csr_pwdata[DIR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ORIGIN_X: csr_prdata = origin_x_ff;
         REG_ORIGIN_Y: csr_prdata = origin_y_ff;
         REG_ORIGIN_Z: csr_prdata = origin_z_ff;
         REG_DIR_X:    csr_prdata = {{(CSR_DATA_W-DIR_W){dir_x_ff[DIR_W-1]}}, dir_x_ff};
         REG_DIR_Y:    csr_prdata = {{(CSR_DATA_W-DIR_W){dir_y_ff[DIR_W-1]}}, dir_y_ff};
         REG_DIR_Z:    csr_prdata = {{(CSR_DATA_W-DIR_W){dir_z_ff[DIR_W-1]}}, dir_z_ff};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         dir_x_ff    <= '0;
         dir_y_ff    <= '0;
         dir_z_ff    <= DIR_Z_RESET;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         origin_z_ff <= origin_z_in;
         dir_x_ff    <= dir_x_in;
         dir_y_ff    <= dir_y_in;
         dir_z_ff    <= dir_z_in;
      end
   end

   rtnh_front u_front (
      .clock    (clock),
      .reset    (reset),
      .origin_x (origin_x_ff),
      .origin_y (origin_y_ff),
      .origin_z (origin_z_ff),
      .req      (req_chan),
      .tri_pop  (tri_pop),
      .q_out    (q_out)
   );

   rtnh_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_out   (q_out),
      .tri_pop (tri_pop),
      .dir_x   (dir_x_ff),
      .dir_y   (dir_y_ff),
      .dir_z   (dir_z_ff),
      .rsp     (rsp_chan)
   );

   `RTNH_ASSERT_SAME(a_pop_not_empty, clock, reset, tri_pop, q_out.valid, "pop from empty queue")
   `RTNH_ASSERT_NEXT(a_single_pop, clock, reset, tri_pop, !tri_pop, "back took two triangles")
   `RTNH_ASSERT_SAME(a_miss_zero, clock, reset, rsp_chan.valid && !rsp_chan.hit_found, (rsp_chan.hit_distance == '0) && (rsp_chan.hit_index == '0), "miss result not zero")

endmodule

FILE: dv/rtnh_hit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnh_hit_checker
// Watches the triangle, result and register ports of the hit engine. Keeps
// its own copy of the ray and of the nearest hit so far, works out each
// mesh result exactly with wide integers, and compares it with what comes out.
// ----------------------------------------------------------------------------
module rtnh_hit_checker
   import rtnh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   rtnh_req_if                   req,
   rtnh_rsp_if                   rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatches,
   output int                    pending,
   output int                    hit_meshes
);

   typedef struct {
      logic               found;
      logic [DIST_W-1:0]  distance;
      logic [INDEX_W-1:0] index;
   } mesh_hit_type;

   typedef logic signed [191:0] wide_type;

   mesh_hit_type       expected_hits[$];
   logic signed [31:0] ray_org[3];
   logic signed [17:0] ray_dir[3];
   logic               near_valid;
   logic [DIST_W-1:0]  near_dist;
   logic [INDEX_W-1:0] near_index;
   logic [INDEX_W-1:0] tri_count;
   int                 fails;

   assign mismatches = fails;
   assign pending    = expected_hits.size();

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
      fails++;
   endtask

   task automatic trace_triangle(input logic [31:0] va[3], input logic [31:0] vb[3],
                                 input logic [31:0] vc[3], input logic last);
      logic signed [63:0] e1[3], e2[3], tv[3], dv[3], p[3];
      wide_type           q[3], d, un, vn, tn, quo;
      logic               hit;
      mesh_hit_type       res;
      for (int i = 0; i < 3; i++) begin
         e1[i] = $signed(vb[i]) - $signed(va[i]);
         e2[i] = $signed(vc[i]) - $signed(va[i]);
         tv[i] = ray_org[i] - $signed(va[i]);
         dv[i] = ray_dir[i];
      end
      p[0] = dv[1] * e2[2] - dv[2] * e2[1];
      p[1] = dv[2] * e2[0] - dv[0] * e2[2];
      p[2] = dv[0] * e2[1] - dv[1] * e2[0];
      q[0] = wide_type'(tv[1]) * e1[2] - wide_type'(tv[2]) * e1[1];
      q[1] = wide_type'(tv[2]) * e1[0] - wide_type'(tv[0]) * e1[2];
      q[2] = wide_type'(tv[0]) * e1[1] - wide_type'(tv[1]) * e1[0];
      d  = wide_type'(p[0]) * e1[0] + wide_type'(p[1]) * e1[1] + wide_type'(p[2]) * e1[2];
      un = wide_type'(p[0]) * tv[0] + wide_type'(p[1]) * tv[1] + wide_type'(p[2]) * tv[2];
      vn = q[0] * dv[0] + q[1] * dv[1] + q[2] * dv[2];
      tn = q[0] * e2[0] + q[1] * e2[1] + q[2] * e2[2];
      if (d < 0) begin
         d = -d; un = -un; vn = -vn; tn = -tn;
      end
      hit = d != 0 && un >= 0 && vn >= 0 && tn >= 0 && un + vn <= d;
      if (hit) begin
         quo = (tn <<< FRAC_BITS) / d;
         if (quo > wide_type'(SAT_DIST)) quo = wide_type'(SAT_DIST);
         if (!near_valid || quo[DIST_W-1:0] < near_dist) begin
            near_valid = 1'b1;
            near_dist  = quo[DIST_W-1:0];
            near_index = tri_count;
         end
      end
      tri_count++;
      if (last) begin
         res.found    = near_valid;
         res.distance = near_valid ? near_dist : '0;
         res.index    = near_valid ? near_index : '0;
         expected_hits.push_back(res);
         near_valid = 1'b0;
         near_dist  = '0;
         near_index = '0;
         tri_count  = '0;
      end
   endtask

   always @(posedge clock) begin
      mesh_hit_type want;
      logic [31:0]  va[3], vb[3], vc[3];
      if (reset) begin
         ray_org    = '{0, 0, 0};
         ray_dir    = '{0, 0, 18'(DIR_Z_RESET)};
         near_valid = 1'b0;
         near_dist  = '0;
         near_index = '0;
         tri_count  = '0;
         fails      = 0;
         hit_meshes = 0;
         expected_hits.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_ORIGIN_X: ray_org[0] = csr_pwdata;
               REG_ORIGIN_Y: ray_org[1] = csr_pwdata;
               REG_ORIGIN_Z: ray_org[2] = csr_pwdata;
               REG_DIR_X:    ray_dir[0] = csr_pwdata[DIR_W-1:0];
               REG_DIR_Y:    ray_dir[1] = csr_pwdata[DIR_W-1:0];
               REG_DIR_Z:    ray_dir[2] = csr_pwdata[DIR_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            va = '{req.vertex_a_x, req.vertex_a_y, req.vertex_a_z};
            vb = '{req.vertex_b_x, req.vertex_b_y, req.vertex_b_z};
            vc = '{req.vertex_c_x, req.vertex_c_y, req.vertex_c_z};
            trace_triangle(va, vb, vc, req.last_triangle);
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_hits.size() == 0) begin
               $display("%0t unexpected result transaction", $time);
               fails++;
            end else begin
               want = expected_hits.pop_front();
               if (want.found) hit_meshes++;
               if (rsp.hit_found !== want.found)
                  report_mismatch("hit_found", rsp.hit_found, want.found);
               if (rsp.hit_distance !== want.distance)
                  report_mismatch("hit_distance", rsp.hit_distance, want.distance);
               if (rsp.hit_index !== want.index)
                  report_mismatch("hit_index", rsp.hit_index, want.index);
            end
         end
      end
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Ray/triangle nearest-hit engine: directed meshes for the corner cases,
// then phases of random rays and meshes aimed at the ray, with random
// idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module testbench;
   import rtnh_pkg::*;

   typedef logic [31:0] vec3_type[3];

   localparam logic [CSR_ADDR_W-1:0] CSR_HOLE_ADDR = 5'd28;
   localparam int                    UNIT          = 1 << FRAC_BITS;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatches, pending, hit_meshes;
   int                    tri_sent, mesh_sent;
   bit                    idle_on, stall_req;
   longint                cur_org[3], cur_dir[3];

   rtnh_req_if req_bus ();
   rtnh_rsp_if rsp_bus ();

   ray_triangle_nearest_hit i_dut (
      .clock, .reset, .req_chan(req_bus), .rsp_chan(rsp_bus),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   rtnh_hit_checker i_checker (
      .clock, .reset, .req(req_bus), .rsp(rsp_bus),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .mismatches, .pending, .hit_meshes
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_ray(input longint org[3], input longint dir[3]);
      csr_write({REG_ORIGIN_X, 2'b00}, 32'(org[0]));
      csr_write({REG_ORIGIN_Y, 2'b00}, 32'(org[1]));
      csr_write({REG_ORIGIN_Z, 2'b00}, 32'(org[2]));
      csr_write({REG_DIR_X, 2'b00}, 32'(dir[0]));
      csr_write({REG_DIR_Y, 2'b00}, 32'(dir[1]));
      csr_write({REG_DIR_Z, 2'b00}, 32'(dir[2]));
      for (int i = 0; i < 3; i++) begin
         cur_org[i] = longint'($signed(32'(org[i])));
         cur_dir[i] = longint'($signed(18'(dir[i])));
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_tri(input vec3_type va, input vec3_type vb, input vec3_type vc,
                           input bit last);
      int gap;
      bit took;
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.vertex_a_x    <= va[0];
      req_bus.vertex_a_y    <= va[1];
      req_bus.vertex_a_z    <= va[2];
      req_bus.vertex_b_x    <= vb[0];
      req_bus.vertex_b_y    <= vb[1];
      req_bus.vertex_b_z    <= vb[2];
      req_bus.vertex_c_x    <= vc[0];
      req_bus.vertex_c_y    <= vc[1];
      req_bus.vertex_c_z    <= vc[2];
      req_bus.last_triangle <= last;
      do begin
         @(negedge clock);
         took = req_bus.ready;
         @(posedge clock);
      end while (!took);
      tri_sent++;
      if (last) mesh_sent++;
   endtask

   function automatic vec3_type units(input int x, input int y, input int z);
      vec3_type v;
      v[0] = 32'(x * UNIT);
      v[1] = 32'(y * UNIT);
      v[2] = 32'(z * UNIT);
      return v;
   endfunction

   // triangle scattered around a point on the ray, sometimes behind the origin
   task automatic send_aimed(input bit last);
      longint   s, h[3];
      vec3_type v[3];
      int       spread;
      s      = longint'($urandom_range(0, 1 << 21)) - (1 << 18);
      spread = 1 << $urandom_range(12, 19);
      for (int i = 0; i < 3; i++) h[i] = cur_org[i] + ((s * cur_dir[i]) >>> FRAC_BITS);
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++)
            v[k][i] = 32'(h[i] + longint'($urandom_range(0, 2 * spread)) - spread);
      send_tri(v[0], v[1], v[2], last);
   endtask

   task automatic send_noise(input bit last);
      vec3_type v[3];
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++) v[k][i] = $urandom;
      send_tri(v[0], v[1], v[2], last);
   endtask

   initial begin
      int gap;
      bit took;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         gap = idle_on ? $urandom_range(0, 11) : 0;
         if (stall_req) begin
            gap       = 3000;
            stall_req = 1'b0;
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do begin
            @(negedge clock);
            took = rsp_bus.valid;
            @(posedge clock);
         end while (!took);
      end
   end

   initial begin
      longint org[3], dir[3];
      int     mesh_len, phase_start;
      reset         = 1'b1;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      req_bus.valid = 1'b0;
      {req_bus.vertex_a_x, req_bus.vertex_a_y, req_bus.vertex_a_z} = '0;
      {req_bus.vertex_b_x, req_bus.vertex_b_y, req_bus.vertex_b_z} = '0;
      {req_bus.vertex_c_x, req_bus.vertex_c_y, req_bus.vertex_c_z} = '0;
      req_bus.last_triangle = 1'b0;
      idle_on   = 1'b1;
      stall_req = 1'b0;
      tri_sent  = 0;
      mesh_sent = 0;
      cur_org   = '{0, 0, 0};
      cur_dir   = '{0, 0, UNIT};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset ray: origin 0, direction +z
      send_tri(units(-1, -1, 5), units(3, -1, 5), units(-1, 3, 5), 1'b0);
      send_tri(units(-1, -1, 5), units(3, -1, 5), units(-1, 3, 5), 1'b0);  // tie
      send_tri(units(-1, -1, 2), units(-1, -1, 2), units(1, 1, 2), 1'b0);   // degenerate
      send_tri(units(-1, -1, 3), units(3, -1, 3), units(-1, 3, 3), 1'b0);   // nearer
      send_tri(units(5, 5, 1), units(7, 5, 1), units(5, 7, 1), 1'b1);      // miss
      send_tri(units(5, 5, 1), units(7, 5, 1), units(5, 7, 1), 1'b1);      // single-triangle mesh with no hit
      send_tri(units(0, -1, 0), units(0, 1, 0), units(0, 0, 5), 1'b1);     // parallel
      send_tri(units(-1, -1, -4), units(3, -1, -4), units(-1, 3, -4), 1'b1); // behind
      send_tri('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
               '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},
               '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b1);
      send_tri('{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff},
               '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},
               '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b1);
      wait_idle();
      // far wall with a tiny step: distance saturates
      org = '{0, 0, -64'sd2147483648};
      dir = '{0, 0, 1};
      set_ray(org, dir);
      send_tri('{32'hc000_0000, 32'hc000_0000, 32'h7fff_ffff},
               '{32'h4000_0000, 32'hc000_0000, 32'h7fff_ffff},
               '{32'hc000_0000, 32'h4000_0000, 32'h7fff_ffff}, 1'b1);
      wait_idle();
      csr_write(CSR_HOLE_ADDR, $urandom);

      for (int ph = 0; ph < 12; ph++) begin
         wait_idle();
         for (int i = 0; i < 3; i++) begin
            org[i] = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            dir[i] = longint'($urandom_range(0, 2 * UNIT)) - UNIT;
         end
         case (ph)
            0: dir = '{0, 0, UNIT};
            1: dir = '{-UNIT, 0, 0};
            3: dir = '{UNIT, UNIT, UNIT};
            4: dir = '{-UNIT, -UNIT, -UNIT};
            5: dir = '{0, 0, 0};
            7: for (int i = 0; i < 3; i++) begin
                  org[i] = $urandom;
                  dir[i] = $urandom;
               end
            default: ;
         endcase
         set_ray(org, dir);
         if (ph == 9) csr_write(CSR_HOLE_ADDR, $urandom);
         idle_on   = !(ph == 4 || ph == 5);
         stall_req = (ph == 2);
         phase_start = tri_sent;
         while (tri_sent - phase_start < 34) begin
            mesh_len = $urandom_range(1, 8);
            for (int k = 0; k < mesh_len; k++) begin
               if ($urandom_range(0, 99) < 85) send_aimed(k == mesh_len - 1);
               else send_noise(k == mesh_len - 1);
            end
         end
      end

      wait_idle();
      repeat (900) @(posedge clock);
      $display("covered %0d triangles in %0d meshes, %0d meshes with a hit",
               tri_sent, mesh_sent, hit_meshes);
      $display("ray settings exercised: 14, including zero and out-of-range directions");
      if (mismatches == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
